// ===== hdl/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg: shared types and constants of the linear-probe hash map
// Table geometry, payload structs, action and status codes, home-slot hash.
// ----------------------------------------------------------------------------
`default_nettype none

package lphm_pkg;

  // TABLE_SLOTS must be a power of two: the slot index wraps by truncation.
  localparam int TABLE_SLOTS = 256;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 16;
  localparam int IDX_W       = $clog2(TABLE_SLOTS);

  localparam logic [63:0] HASH_MULT = 64'd2654435761;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_KEY_ZERO  = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] result_value;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // One update of the occupancy flags.
  typedef struct packed {
    logic wr;
    logic set_val;
    idx_t idx;
  } occ_cmd_t;

  // Low bits of key * HASH_MULT depend only on the low bits of both factors.
  function automatic idx_t home_slot(input logic [KEY_BITS-1:0] key);
    idx_t k;
    idx_t m;
    k = key[IDX_W-1:0];
    m = HASH_MULT[IDX_W-1:0];
    return IDX_W'(k * m);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/linear_probe_hash_map_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core: open-addressing hash map with linear probing
// Maps a nonzero 32-bit key to a 16-bit value; lookup, insert and remove.
// ----------------------------------------------------------------------------
//
//   channel | ports                         | dir | transfer when
//   --------+-------------------------------+-----+------------------------
//   in      | in_valid, in_ready, in_data   | in  | in_valid && in_ready
//   out     | out_valid, out_ready, out_data| out | out_valid && out_ready
//
// A lookup or insert probes P slots (1 for a hit at the home slot, up to
// 256 on a full table), stepping one slot per cycle on the single slot-RAM
// read port. A remove that hits then, for each later entry of the cluster,
// lifts it out and probes again from its home slot to re-place it, and
// reads one more slot to find the cluster end. Reset clears the occupancy
// flags; no clearing pass runs.
// One item is in work at a time; the output register lets the next item
// enter while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_map_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lphm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lphm_pkg::out_item_t      out_data
);

  import lphm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_RM_SCAN,
    S_RM_LOAD,
    S_RM_PLACE,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            act_r, act_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  idx_t                  cur_r, cur_nxt;     // slot under probe
  idx_t                  cnt_r, cnt_nxt;     // slots probed so far, minus one
  idx_t                  j_r, j_nxt;         // next cluster slot to move on remove
  idx_t                  n_r, n_nxt;         // cluster slots visited on remove
  logic [KEY_BITS-1:0]   tk_r, tk_nxt;       // entry being re-placed
  logic [VALUE_BITS-1:0] tv_r, tv_nxt;
  out_item_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic       ram_we;
  idx_t       ram_waddr;
  slot_t      ram_wdata;
  idx_t       ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t      slot_rd;

  occ_cmd_t   occ_cmd;
  idx_t       occ_rd_idx;
  logic       occ_rd;

  logic       probe_hit;
  logic       probe_empty;
  logic       probe_end;

  // Key/value store; only slots flagged occupied hold meaningful data.
  lphm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (SLOT_W'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lphm_occ u_occ (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (occ_cmd),
    .rd_idx (occ_rd_idx),
    .rd_bit (occ_rd)
  );

  assign slot_rd = slot_t'(ram_rdata);

  // Probe outcome for the slot whose data arrived this cycle.
  assign probe_empty = !occ_rd;
  assign probe_hit   = occ_rd && (slot_rd.key == key_r);
  assign probe_end   = probe_hit || probe_empty || (cnt_r == '1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    tk_nxt        = tk_r;
    tv_nxt        = tv_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    ram_we     = 1'b0;
    ram_waddr  = cur_r;
    ram_wdata  = '{key: key_r, value: val_r};
    ram_raddr  = cur_r;
    occ_cmd    = '{wr: 1'b0, set_val: 1'b0, idx: cur_r};
    occ_rd_idx = cur_r;

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Start the read of the home slot so its data is ready in S_FIND.
        ram_raddr = home_slot(in_data.key);
        if (in_valid) begin
          act_nxt = in_data.action;
          key_nxt = in_data.key;
          val_nxt = in_data.value;
          cur_nxt = home_slot(in_data.key);
          cnt_nxt = '0;
          if (in_data.action == ACT_NOP) begin
            res_nxt   = '{status: ST_OK, found: 1'b0, result_value: '0};
            state_nxt = S_DONE;
          end else if (in_data.key == '0) begin
            res_nxt   = '{status: ST_KEY_ZERO, found: 1'b0, result_value: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      S_FIND: begin
        // Read the following slot ahead; ignored if the probe ends here.
        ram_raddr = cur_r + IDX_W'(1);
        if (!probe_end) begin
          cur_nxt = cur_r + IDX_W'(1);
          cnt_nxt = cnt_r + IDX_W'(1);
        end else begin
          state_nxt = S_DONE;
          case (act_r)
            ACT_LOOKUP: begin
              if (probe_hit) begin
                res_nxt = '{status: ST_OK, found: 1'b1, result_value: slot_rd.value};
              end else begin
                res_nxt = '{status: ST_NOT_FOUND, found: 1'b0, result_value: '0};
              end
            end
            ACT_INSERT: begin
              if (probe_hit || probe_empty) begin
                ram_we  = 1'b1;
                occ_cmd = '{wr: probe_empty, set_val: 1'b1, idx: cur_r};
                res_nxt = '{status: ST_OK, found: probe_hit, result_value: '0};
              end else begin
                res_nxt = '{status: ST_FULL, found: 1'b0, result_value: '0};
              end
            end
            ACT_REMOVE: begin
              if (probe_hit) begin
                occ_cmd   = '{wr: 1'b1, set_val: 1'b0, idx: cur_r};
                res_nxt   = '{status: ST_OK, found: 1'b1, result_value: '0};
                j_nxt     = cur_r + IDX_W'(1);
                n_nxt     = IDX_W'(1);
                state_nxt = S_RM_SCAN;
              end else begin
                res_nxt = '{status: ST_NOT_FOUND, found: 1'b0, result_value: '0};
              end
            end
            default: begin
              res_nxt = '{status: ST_OK, found: 1'b0, result_value: '0};
            end
          endcase
        end
      end

      S_RM_SCAN: begin
        // Continue while the cluster goes on and the whole ring is not done.
        occ_rd_idx = j_r;
        ram_raddr  = j_r;
        if ((n_r != '0) && occ_rd) begin
          state_nxt = S_RM_LOAD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RM_LOAD: begin
        // Lift the entry out of its slot and probe again from its home.
        tk_nxt    = slot_rd.key;
        tv_nxt    = slot_rd.value;
        occ_cmd   = '{wr: 1'b1, set_val: 1'b0, idx: j_r};
        cur_nxt   = home_slot(slot_rd.key);
        state_nxt = S_RM_PLACE;
      end

      S_RM_PLACE: begin
        // Keys are unique, so the first free slot is where it goes.
        if (!occ_rd) begin
          ram_we    = 1'b1;
          ram_wdata = '{key: tk_r, value: tv_r};
          occ_cmd   = '{wr: 1'b1, set_val: 1'b1, idx: cur_r};
          j_nxt     = j_r + IDX_W'(1);
          n_nxt     = n_r + IDX_W'(1);
          state_nxt = S_RM_SCAN;
        end else begin
          cur_nxt = cur_r + IDX_W'(1);
        end
      end

      S_DONE: begin
        // Hold until the output register is free, then hand the result over.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    cnt_r      <= cnt_nxt;
    j_r        <= j_nxt;
    n_r        <= n_nxt;
    tk_r       <= tk_nxt;
    tv_r       <= tv_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result appears only when the sequencer finishes an item.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  // A zero key on a real action finishes at once with the key-zero status.
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.key == '0) && (in_data.action != ACT_NOP))
      |=> (state_r == S_DONE) && (res_r.status == ST_KEY_ZERO))
    else $error("zero key not rejected");

  // The store changes only at the end of a probe or while re-placing.
  a_ram_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_FIND) || (state_r == S_RM_PLACE)))
    else $error("slot write outside probe end or re-place");

  // Occupancy is never touched while waiting for an item or handing a result.
  a_occ_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_DONE)) |-> !occ_cmd.wr)
    else $error("occupancy update while idle");

endmodule

`default_nettype wire

// ===== hdl/lphm_ram.sv =====
// ----------------------------------------------------------------------------
// lphm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/lphm_occ.sv =====
// ----------------------------------------------------------------------------
// lphm_occ: slot occupancy flags
// One flag per slot, cleared at reset, one set or clear per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lphm_occ (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lphm_pkg::occ_cmd_t cmd,
  input  wire lphm_pkg::idx_t     rd_idx,
  output logic                    rd_bit
);

  import lphm_pkg::*;

  logic [TABLE_SLOTS-1:0] occ_r;
  logic [TABLE_SLOTS-1:0] occ_nxt;

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.wr) begin
      occ_nxt[cmd.idx] = cmd.set_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign rd_bit = occ_r[rd_idx];

endmodule

`default_nettype wire

// ===== tb/tb_linear_probe_hash_map_core.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_map_core: self-checking bench for the hash map core
// Runs a short directed script, then clustered random traffic and a fill to
// a full table. Every result is checked against a local model of the map
// or a typed-in result. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_map_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lphm_pkg::*;

  localparam int IDLE_PCT     = 38;    // idle chance per cycle, both sides
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_AT      = 300;   // transfers seen before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;   // 1: want holds the result, 0: take it from the model
    out_item_t want;
  } script_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Model of the table: key 0 marks a free slot.
  logic [KEY_BITS-1:0]   map_keys [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] map_vals [TABLE_SLOTS];

  out_item_t   replies_due [$];
  script_row_t script [$];
  int          failures     = 0;
  int          replies_seen = 0;
  bit          steady       = 1'b0;  // suppress idling on both sides

  linear_probe_hash_map_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Map model
  // --------------------------------------------------------------------------

  // Home slot: low index bits of the full 64-bit product.
  function automatic idx_t hash_slot(input logic [KEY_BITS-1:0] k);
    logic [63:0] prod;
    prod = 64'(k) * HASH_MULT;
    return prod[IDX_W-1:0];
  endfunction

  // Walk the probe chain; stop at the key, at a free slot or after a full lap.
  function automatic bit locate(input logic [KEY_BITS-1:0] k, output idx_t at);
    idx_t s;
    s  = hash_slot(k);
    at = '0;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (map_keys[s] == '0) return 1'b0;
      if (map_keys[s] == k) begin
        at = s;
        return 1'b1;
      end
      s = idx_t'(s + 1);
    end
    return 1'b0;
  endfunction

  // Store at the first free or matching slot of the chain.
  function automatic bit settle(input logic [KEY_BITS-1:0] k,
                                input logic [VALUE_BITS-1:0] v);
    idx_t s;
    s = hash_slot(k);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (map_keys[s] == '0 || map_keys[s] == k) begin
        map_keys[s] = k;
        map_vals[s] = v;
        return 1'b1;
      end
      s = idx_t'(s + 1);
    end
    return 1'b0;
  endfunction

  // Apply one action to the model and return the result it yields.
  function automatic out_item_t map_apply(input in_item_t item);
    out_item_t             r;
    idx_t                  s;
    idx_t                  j;
    logic [KEY_BITS-1:0]   mk;
    logic [VALUE_BITS-1:0] mv;
    r = '0;
    if (item.action == ACT_NOP) return r;
    if (item.key == '0) begin
      r.status = ST_KEY_ZERO;
      return r;
    end
    r.found = locate(item.key, s);
    case (item.action)
      ACT_LOOKUP: begin
        if (r.found) r.result_value = map_vals[s];
        else r.status = ST_NOT_FOUND;
      end
      ACT_INSERT: begin
        if (r.found) map_vals[s] = item.value;
        else if (!settle(item.key, item.value)) r.status = ST_FULL;
      end
      ACT_REMOVE: begin
        if (!r.found) begin
          r.status = ST_NOT_FOUND;
        end else begin
          map_keys[s] = '0;
          map_vals[s] = '0;
          // Pull out the rest of the cluster and place each entry again.
          j = idx_t'(s + 1);
          for (int n = 1; n < TABLE_SLOTS && map_keys[j] != '0; n++) begin
            mk = map_keys[j];
            mv = map_vals[j];
            map_keys[j] = '0;
            map_vals[j] = '0;
            void'(settle(mk, mv));
            j = idx_t'(j + 1);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int map_fill();
    int c;
    c = 0;
    foreach (map_keys[i]) if (map_keys[i] != '0) c++;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic in_item_t mk_item(input logic [1:0] act,
                                       input logic [KEY_BITS-1:0] k,
                                       input logic [VALUE_BITS-1:0] v);
    in_item_t it;
    it.action = act;
    it.key    = k;
    it.value  = v;
    return it;
  endfunction

  function automatic out_item_t reply(input logic [1:0] st, input logic f,
                                      input logic [VALUE_BITS-1:0] v);
    out_item_t r;
    r.status       = st;
    r.found        = f;
    r.result_value = v;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input logic typed,
                                  input out_item_t want);
    script_row_t row;
    row.stim  = it;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endfunction

  // Search the low byte that lands a key with the given upper bits on slot h.
  function automatic logic [KEY_BITS-1:0] key_at_home(input idx_t h,
                                                      input logic [23:0] upper);
    logic [KEY_BITS-1:0] k;
    k = {upper, 8'h00};
    for (int b = 0; b < 256; b++) begin
      k = {upper, 8'(b)};
      if (hash_slot(k) == h) return k;
    end
    return k;
  endfunction

  // Nonzero key not present in the table.
  function automatic logic [KEY_BITS-1:0] fresh_key();
    logic [KEY_BITS-1:0] k;
    idx_t                at;
    do k = $urandom; while (k == '0 || locate(k, at));
    return k;
  endfunction

  // Key of a random occupied slot; the table must not be empty.
  function automatic logic [KEY_BITS-1:0] stored_key();
    logic [KEY_BITS-1:0] k;
    do k = map_keys[$urandom_range(TABLE_SLOTS - 1)]; while (k == '0);
    return k;
  endfunction

  // Offer one item, hold it until the transfer, then record what it must yield.
  task automatic send(input in_item_t item, input logic typed, input out_item_t want);
    out_item_t calc;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    // Update the model at the transfer even when the reply is typed in.
    calc = map_apply(item);
    replies_due.push_back(typed ? want : calc);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void note_failure(input string what, input out_item_t want,
                                       input out_item_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s: expected status %0d found %0d value %h", $time, what,
               want.status, want.found, want.result_value);
      $display("%0t: %s: actual   status %0d found %0d value %h", $time, what,
               got.status, got.found, got.result_value);
    end
  endfunction

  function automatic void check_reply(input out_item_t got);
    out_item_t want;
    replies_seen++;
    if (replies_due.size() == 0) begin
      note_failure("result with nothing pending", '0, got);
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status || got.found !== want.found ||
        got.result_value !== want.result_value) begin
      note_failure("result mismatch", want, got);
    end
  endfunction

  // Result side: check each transfer, drive ready for the next edge. Once,
  // hold ready low for a long stretch so the core fills up and stalls input.
  initial begin : reply_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_reply(out_data);
      if (!hold_done && replies_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin : watchdog
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [KEY_BITS-1:0] pool [$];
    logic [KEY_BITS-1:0] k;
    logic [KEY_BITS-1:0] ka, kb, kc, kw1, kw2, kz;
    idx_t                hot_homes [8];
    int                  pick;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (map_keys[i]) begin
      map_keys[i] = '0;
      map_vals[i] = '0;
    end

    // Hold reset, then release once.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three keys sharing home slot 7, two on the last slot (the chain wraps
    // to slot 0) and one homed at slot 0 that lands behind them.
    ka  = key_at_home(8'd7,   24'h00A5C3);
    kb  = key_at_home(8'd7,   24'h5A3C01);
    kc  = key_at_home(8'd7,   24'hFFFFFF);
    kw1 = key_at_home(8'd255, 24'h123456);
    kw2 = key_at_home(8'd255, 24'h800000);
    kz  = key_at_home(8'd0,   24'h000001);

    // Empty table, zero key on every action, unused action code.
    add_row(mk_item(ACT_LOOKUP, 32'd5, 16'h0000), 1'b1, reply(ST_NOT_FOUND, 1'b0, 16'h0));
    add_row(mk_item(ACT_REMOVE, 32'd5, 16'h0000), 1'b1, reply(ST_NOT_FOUND, 1'b0, 16'h0));
    add_row(mk_item(ACT_INSERT, 32'd0, 16'hFFFF), 1'b1, reply(ST_KEY_ZERO, 1'b0, 16'h0));
    add_row(mk_item(ACT_LOOKUP, 32'd0, 16'hFFFF), 1'b1, reply(ST_KEY_ZERO, 1'b0, 16'h0));
    add_row(mk_item(ACT_REMOVE, 32'd0, 16'hFFFF), 1'b1, reply(ST_KEY_ZERO, 1'b0, 16'h0));
    add_row(mk_item(ACT_NOP, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, reply(ST_OK, 1'b0, 16'h0));
    // Extreme key and value, then an update in place.
    add_row(mk_item(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, reply(ST_OK, 1'b0, 16'h0));
    add_row(mk_item(ACT_LOOKUP, 32'hFFFF_FFFF, 16'h0000), 1'b1, reply(ST_OK, 1'b1, 16'hFFFF));
    add_row(mk_item(ACT_INSERT, 32'hFFFF_FFFF, 16'h0000), 1'b1, reply(ST_OK, 1'b1, 16'h0));
    add_row(mk_item(ACT_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, reply(ST_OK, 1'b1, 16'h0));
    add_row(mk_item(ACT_INSERT, 32'd1, 16'h8001), 1'b1, reply(ST_OK, 1'b0, 16'h0));
    // Collisions: build a cluster, remove its head, probe past the gap.
    add_row(mk_item(ACT_INSERT, ka, 16'h1111), 1'b0, '0);
    add_row(mk_item(ACT_INSERT, kb, 16'h2222), 1'b0, '0);
    add_row(mk_item(ACT_INSERT, kc, 16'h3333), 1'b0, '0);
    add_row(mk_item(ACT_LOOKUP, kc, 16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_REMOVE, ka, 16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_LOOKUP, kc, 16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_LOOKUP, kb, 16'h0000), 1'b0, '0);
    // Wrap from the last slot to slot 0, then close the gap across it.
    add_row(mk_item(ACT_INSERT, kw1, 16'hA5A5), 1'b0, '0);
    add_row(mk_item(ACT_INSERT, kw2, 16'h5A5A), 1'b0, '0);
    add_row(mk_item(ACT_INSERT, kz,  16'h0F0F), 1'b0, '0);
    add_row(mk_item(ACT_REMOVE, kw1, 16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_LOOKUP, kz,  16'h0000), 1'b0, '0);
    add_row(mk_item(ACT_REMOVE, 32'd1, 16'h0000), 1'b1, reply(ST_OK, 1'b1, 16'h0));
    add_row(mk_item(ACT_LOOKUP, 32'd1, 16'h0000), 1'b1, reply(ST_NOT_FOUND, 1'b0, 16'h0));

    foreach (script[i]) send(script[i].stim, script[i].typed, script[i].want);

    // Key pool: half the keys crowd onto a few home slots (two groups, one
    // wrapping past the last slot) to grow long clusters, half are spread.
    hot_homes = '{8'd254, 8'd255, 8'd0, 8'd1, 8'd100, 8'd101, 8'd102, 8'd103};
    for (int i = 0; i < 48; i++) begin
      pool.push_back(key_at_home(hot_homes[i % 8], 24'($urandom_range(24'hFFFFFF, 1))));
    end
    for (int i = 0; i < 48; i++) begin
      k = $urandom;
      pool.push_back((k == '0) ? 32'd1 : k);
    end

    // Mostly well-formed traffic on the pool, with a little noise.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 500 && i < 700);
      pick   = $urandom_range(99);
      k      = pool[$urandom_range(pool.size() - 1)];
      if (pick < 4) begin
        send(mk_item(ACT_NOP, $urandom, VALUE_BITS'($urandom)), 1'b0, '0);
      end else if (pick < 7) begin
        send(mk_item(2'($urandom_range(2)), '0, VALUE_BITS'($urandom)), 1'b0, '0);
      end else if (pick < 45) begin
        send(mk_item(ACT_INSERT, k, VALUE_BITS'($urandom)), 1'b0, '0);
      end else if (pick < 68) begin
        send(mk_item(ACT_LOOKUP, k, VALUE_BITS'($urandom)), 1'b0, '0);
      end else if (pick < 75) begin
        send(mk_item(ACT_LOOKUP, fresh_key(), VALUE_BITS'($urandom)), 1'b0, '0);
      end else begin
        send(mk_item(ACT_REMOVE, k, VALUE_BITS'($urandom)), 1'b0, '0);
      end
    end
    steady = 1'b0;

    // Fill every slot with new keys.
    while (map_fill() < TABLE_SLOTS) begin
      send(mk_item(ACT_INSERT, fresh_key(), VALUE_BITS'($urandom)), 1'b0, '0);
    end

    // Full table: new keys are refused, updates still land, misses walk a lap.
    for (int i = 0; i < 32; i++) begin
      case (i % 8)
        0, 6: send(mk_item(ACT_INSERT, fresh_key(), VALUE_BITS'($urandom)), 1'b0, '0);
        1:    send(mk_item(ACT_INSERT, stored_key(), VALUE_BITS'($urandom)), 1'b0, '0);
        2:    send(mk_item(ACT_LOOKUP, fresh_key(), VALUE_BITS'($urandom)), 1'b0, '0);
        4:    send(mk_item(ACT_NOP, stored_key(), VALUE_BITS'($urandom)), 1'b0, '0);
        5:    send(mk_item(ACT_INSERT, '0, VALUE_BITS'($urandom)), 1'b0, '0);
        default: send(mk_item(ACT_LOOKUP, stored_key(), VALUE_BITS'($urandom)), 1'b0, '0);
      endcase
    end

    // Remove from a full table, confirm the miss, refill, and overflow again.
    for (int i = 0; i < 2; i++) begin
      k = stored_key();
      send(mk_item(ACT_REMOVE, k, VALUE_BITS'($urandom)), 1'b0, '0);
      send(mk_item(ACT_LOOKUP, k, VALUE_BITS'($urandom)), 1'b0, '0);
      send(mk_item(ACT_INSERT, fresh_key(), VALUE_BITS'($urandom)), 1'b0, '0);
      send(mk_item(ACT_INSERT, fresh_key(), VALUE_BITS'($urandom)), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then watch a while longer for stray results.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lphm_pkg.sv
hdl/lphm_ram.sv
hdl/lphm_occ.sv
hdl/linear_probe_hash_map_core.sv
tb/tb_linear_probe_hash_map_core.sv
